/* design/pot_trim_scaler_macros.svh */
// ----------------------------------------------------------------------------
// pot_trim_scaler_macros.svh
// Assertion shorthands used by the pot trim scaler sequencer (pts_ctrl).
// ----------------------------------------------------------------------------
`ifndef POT_TRIM_SCALER_MACROS_SVH
`define POT_TRIM_SCALER_MACROS_SVH

// Check a same-cycle implication on clk, quiet while rst_n is low.
`define PTS_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent on clk, quiet while rst_n is low.
`define PTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/pts_pkg.sv */
// ----------------------------------------------------------------------------
// pts_pkg
// Types, codes and constants shared by the pot trim scaler modules.
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int NUM_POTS_DEF = 4;
    localparam int MAX_POTS     = 4;

    // Divider widths: (raw - min) * 6 stays within +-393210.
    localparam int DVD_W = 20;
    localparam int MAG_W = 19;
    localparam int DVS_W = 16;
    localparam int CNT_W = $clog2(MAG_W + 1);

    // Configuration register indexes (byte address = 4 * index).
    localparam logic [2:0] REG_RAW_CEILING   = 3'd0;
    localparam logic [2:0] REG_DESIRED_MIN   = 3'd1;
    localparam logic [2:0] REG_DESIRED_MAX   = 3'd2;
    localparam logic [2:0] REG_ABSOLUTE_MAX  = 3'd3;
    localparam logic [2:0] REG_DEF_MIN_TRIM  = 3'd4;
    localparam logic [2:0] REG_DEF_MAX_TRIM  = 3'd5;
    localparam logic [2:0] REG_DEF_FACTOR    = 3'd6;

    typedef enum logic [1:0] {
        OP_SAMPLE  = 2'd0,
        OP_MIN     = 2'd1,
        OP_MAX     = 2'd2,
        OP_FACTOR  = 2'd3
    } pts_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WAIT,
        ST_DONE
    } pts_state_t;

    typedef struct packed {
        logic [15:0] raw_ceiling;
        logic [7:0]  desired_min;
        logic [7:0]  desired_max;
        logic [7:0]  absolute_max;
        logic [15:0] default_min_trim;
        logic [15:0] default_max_trim;
        logic [15:0] default_factor;
    } pts_cfg_t;

    // Controller to datapath strobes.
    typedef struct packed {
        logic load_item;
        logic exec;
        logic div_start;
        logic writeback;
        logic next_chan;
        logic load_out;
    } pts_ctl_t;

    // Datapath to controller status.
    typedef struct packed {
        logic need_div;
        logic last_chan;
        logic div_busy;
        logic div_done;
    } pts_sts_t;

endpackage

/* design/pot_trim_scaler.sv */
// ----------------------------------------------------------------------------
// pot_trim_scaler
// Turns potentiometer charge-time captures into trimmed 8-bit stick readings.
// ----------------------------------------------------------------------------
// Each input word carries a command: a sample stores a channel's capture and,
// when the capture is not above the raw ceiling register, rescales it to
// ((raw - min) * 6) / factor + desired_min, capped at absolute_max and floored
// at zero; a capture above the ceiling only raises the channel's invalid flag.
// The calibration commands act on both channels of one stick: latch the stored
// captures as min or max trims, or recompute the factor from those trims.
// Every input word yields exactly one result word with all four readings and
// the status byte (invalid flags high nibble, buttons low nibble).
// One word is in flight at a time. The serial divider retires one quotient
// bit per cycle over 19 bits and is run once per sample and once per stick
// channel for a factor. A sample that needs no division (capture out of range,
// or a zero factor, which gives absolute_max) skips it, and a factor command
// skips the divider on a channel whose trims are not below the ceiling. The
// result sits in an output register, so the next word is accepted while a
// finished word still waits.
// Configuration goes through the APB-style port at byte address 4 * index;
// write registers only while the block is idle.
// ----------------------------------------------------------------------------
module pot_trim_scaler #(
    parameter int NUM_POTS = pts_pkg::NUM_POTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input words
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  cmd,
    input  logic [1:0]  channel,
    input  logic [15:0] raw_time,
    input  logic        stick,
    input  logic [3:0]  buttons,
    // Result words
    output logic        result_valid,
    input  logic        result_stall,
    output logic [7:0]  joy1_x,
    output logic [7:0]  joy1_y,
    output logic [7:0]  joy2_x,
    output logic [7:0]  joy2_y,
    output logic [7:0]  status_byte
);
    import pts_pkg::*;

    pts_cfg_t   cfg_reg;
    pts_ctl_t   ctl;
    pts_sts_t   sts;
    logic       wr_en;
    logic [2:0] reg_idx;

    // Registers sit on word boundaries; the low address bits are ignored.
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.raw_ceiling      <= 16'd4000;
            cfg_reg.desired_min      <= 8'd8;
            cfg_reg.desired_max      <= 8'd247;
            cfg_reg.absolute_max     <= 8'd247;
            cfg_reg.default_min_trim <= 16'd0;
            cfg_reg.default_max_trim <= 16'd4000;
            cfg_reg.default_factor   <= 16'd100;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_RAW_CEILING:   cfg_reg.raw_ceiling      <= pwdata[15:0];
                REG_DESIRED_MIN:   cfg_reg.desired_min      <= pwdata[7:0];
                REG_DESIRED_MAX:   cfg_reg.desired_max      <= pwdata[7:0];
                REG_ABSOLUTE_MAX:  cfg_reg.absolute_max     <= pwdata[7:0];
                REG_DEF_MIN_TRIM:  cfg_reg.default_min_trim <= pwdata[15:0];
                REG_DEF_MAX_TRIM:  cfg_reg.default_max_trim <= pwdata[15:0];
                REG_DEF_FACTOR:    cfg_reg.default_factor   <= pwdata[15:0];
                default: ;  // drop writes past the register list
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_RAW_CEILING:   prdata = {16'd0, cfg_reg.raw_ceiling};
            REG_DESIRED_MIN:   prdata = {24'd0, cfg_reg.desired_min};
            REG_DESIRED_MAX:   prdata = {24'd0, cfg_reg.desired_max};
            REG_ABSOLUTE_MAX:  prdata = {24'd0, cfg_reg.absolute_max};
            REG_DEF_MIN_TRIM:  prdata = {16'd0, cfg_reg.default_min_trim};
            REG_DEF_MAX_TRIM:  prdata = {16'd0, cfg_reg.default_max_trim};
            REG_DEF_FACTOR:    prdata = {16'd0, cfg_reg.default_factor};
            default:           prdata = 32'd0;
        endcase
    end

    // Sequencer: accepts a word, steps through its channels, hands off result.
    pts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item_valid),
        .in_stall  (item_stall),
        .out_valid (result_valid),
        .out_stall (result_stall),
        .ctl       (ctl),
        .sts       (sts)
    );

    // Stores, arithmetic, divider and the result register.
    pts_datapath #(
        .NUM_POTS (NUM_POTS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .cmd         (cmd),
        .channel     (channel),
        .raw_time    (raw_time),
        .stick       (stick),
        .buttons     (buttons),
        .ctl         (ctl),
        .sts         (sts),
        .joy1_x      (joy1_x),
        .joy1_y      (joy1_y),
        .joy2_x      (joy2_x),
        .joy2_y      (joy2_y),
        .status_byte (status_byte)
    );

endmodule

/* design/pts_divider.sv */
// ----------------------------------------------------------------------------
// pts_divider
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module pts_divider (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [pts_pkg::DVD_W-1:0]  dividend,
    input  logic signed [pts_pkg::DVS_W-1:0]  divisor,
    output logic                              busy,
    output logic                              done,
    output logic signed [pts_pkg::DVD_W-1:0]  quotient
);
    import pts_pkg::*;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [MAG_W-1:0] num_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] den_reg;
    logic             neg_reg;

    logic [DVD_W-1:0] dvd_abs;
    logic [DVS_W-1:0] dvs_abs;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   trial_sub;
    logic             fits;
    logic [DVD_W-1:0] q_mag;

    assign dvd_abs = dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
    assign dvs_abs = divisor[DVS_W-1] ? DVS_W'(-divisor) : DVS_W'(divisor);

    // Bring down the next dividend bit and try the subtract.
    assign trial     = {rem_reg, num_reg[MAG_W-1]};
    assign trial_sub = trial - {1'b0, den_reg};
    assign fits      = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(MAG_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dvd_abs[MAG_W-1:0];
            den_reg <= dvs_abs;
            rem_reg <= '0;
            neg_reg <= dividend[DVD_W-1] ^ divisor[DVS_W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
            num_reg <= {num_reg[MAG_W-2:0], fits};
        end
    end

    assign q_mag    = {{(DVD_W-MAG_W){1'b0}}, num_reg};
    assign quotient = neg_reg ? $signed(-q_mag) : $signed(q_mag);
    assign busy     = busy_reg;
    assign done     = done_reg;

endmodule

/* design/pts_datapath.sv */
// ----------------------------------------------------------------------------
// pts_datapath
// Per-pot stores, trim selection, operand setup, writeback and result word.
// ----------------------------------------------------------------------------
module pts_datapath #(
    parameter int NUM_POTS = pts_pkg::NUM_POTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pts_pkg::pts_cfg_t cfg,
    input  logic [1:0]        cmd,
    input  logic [1:0]        channel,
    input  logic [15:0]       raw_time,
    input  logic              stick,
    input  logic [3:0]        buttons,
    input  pts_pkg::pts_ctl_t ctl,
    output pts_pkg::pts_sts_t sts,
    output logic [7:0]        joy1_x,
    output logic [7:0]        joy1_y,
    output logic [7:0]        joy2_x,
    output logic [7:0]        joy2_y,
    output logic [7:0]        status_byte
);
    import pts_pkg::*;

    localparam int         IDX_W   = $clog2(NUM_POTS);
    localparam logic [2:0] POTS_W3 = 3'(NUM_POTS);

    // Item held for the whole operation.
    pts_op_t     op_reg;
    logic [15:0] raw_reg;
    logic [3:0]  btn_reg;
    logic [1:0]  idx_reg;

    // Per-pot state.
    logic [15:0]         cap_reg [NUM_POTS];
    logic [15:0]         min_reg [NUM_POTS];
    logic [15:0]         max_reg [NUM_POTS];
    logic [15:0]         fac_reg [NUM_POTS];
    logic [2:0]          tw_reg  [NUM_POTS];
    logic [7:0]          pot_reg [NUM_POTS];
    logic [NUM_POTS-1:0] inv_reg;

    // Result word.
    logic [7:0] out_pot_reg [MAX_POTS];
    logic [7:0] out_stat_reg;

    logic                    present;
    logic [IDX_W-1:0]        ix;
    logic [15:0]             eff_min;
    logic [15:0]             eff_max;
    logic signed [15:0]      eff_fac;
    logic                    raw_ok;
    logic                    fac_zero;
    logic                    trims_ok;
    logic signed [9:0]       den;
    logic [15:0]             top_val;
    logic signed [16:0]      diff;
    logic signed [DVD_W-1:0] diff_ext;
    logic signed [DVD_W-1:0] dvd;
    logic signed [DVS_W-1:0] dvs;
    logic                    need_div;
    logic                    div_busy;
    logic                    div_done;
    logic signed [DVD_W-1:0] quot;
    logic signed [DVD_W:0]   samp_sum;
    logic [7:0]              samp_val;
    logic [15:0]             fac_sat;
    logic [7:0]              snap_pot [MAX_POTS];
    logic [MAX_POTS-1:0]     snap_inv;

    assign present = ({1'b0, idx_reg} < POTS_W3);
    assign ix      = present ? idx_reg[IDX_W-1:0] : '0;

    // Fall back to the default registers until a trim is latched.
    assign eff_min = tw_reg[ix][0] ? min_reg[ix] : cfg.default_min_trim;
    assign eff_max = tw_reg[ix][1] ? max_reg[ix] : cfg.default_max_trim;
    assign eff_fac = tw_reg[ix][2] ? $signed(fac_reg[ix]) : $signed(cfg.default_factor);

    assign raw_ok   = (raw_reg <= cfg.raw_ceiling);
    assign fac_zero = (eff_fac == 16'sd0);
    assign trims_ok = (eff_max < cfg.raw_ceiling) && (eff_min < cfg.raw_ceiling);
    assign den      = $signed({2'b00, cfg.desired_max}) - $signed({2'b00, cfg.desired_min})
                      + 10'sd1;

    // Dividend is (raw - min) * 6 for a sample, (max - min) * 6 for a factor.
    assign top_val  = (op_reg == OP_SAMPLE) ? raw_reg : eff_max;
    assign diff     = $signed({1'b0, top_val}) - $signed({1'b0, eff_min});
    assign diff_ext = DVD_W'(diff);
    assign dvd      = (diff_ext <<< 2) + (diff_ext <<< 1);
    assign dvs      = (op_reg == OP_SAMPLE) ? eff_fac : DVS_W'(den);

    always_comb
    begin
        unique case (op_reg)
            OP_SAMPLE: need_div = present && raw_ok && !fac_zero;
            OP_FACTOR: need_div = present && trims_ok && (den != 10'sd0);
            OP_MIN,
            OP_MAX:    need_div = 1'b0;
        endcase
    end

    pts_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (dvd),
        .divisor  (dvs),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quot)
    );

    // Sample writeback: add the offset, cap at absolute_max, floor at zero.
    assign samp_sum = DVD_W'(quot) + $signed({{(DVD_W-7){1'b0}}, cfg.desired_min});

    always_comb
    begin
        priority if (samp_sum > $signed({{(DVD_W-7){1'b0}}, cfg.absolute_max}))
            samp_val = cfg.absolute_max;
        else if (samp_sum < 0)
            samp_val = 8'd0;
        else
            samp_val = samp_sum[7:0];
    end

    // Factor writeback: saturate to 16-bit signed.
    always_comb
    begin
        priority if (quot > 20'sd32767)
            fac_sat = 16'h7FFF;
        else if (quot < -20'sd32768)
            fac_sat = 16'h8000;
        else
            fac_sat = quot[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_item)
        begin
            op_reg  <= pts_op_t'(cmd);
            raw_reg <= raw_time;
            btn_reg <= buttons;
            idx_reg <= (pts_op_t'(cmd) == OP_SAMPLE) ? channel : {stick, 1'b0};
        end
        else if (ctl.next_chan)
        begin
            idx_reg <= {idx_reg[1], 1'b1};
        end
    end

    // Trims and factors need no reset: the written bits mask them.
    always_ff @(posedge clk)
    begin
        if (ctl.exec && present && (op_reg == OP_MIN))
            min_reg[ix] <= cap_reg[ix];
        if (ctl.exec && present && (op_reg == OP_MAX))
            max_reg[ix] <= cap_reg[ix];
        if (ctl.writeback && (op_reg == OP_FACTOR))
            fac_reg[ix] <= fac_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_POTS; i++)
            begin
                cap_reg[i] <= '0;
                tw_reg[i]  <= '0;
                pot_reg[i] <= '0;
            end
            inv_reg <= '0;
        end
        else
        begin
            if (ctl.exec && present)
            begin
                unique case (op_reg)
                    OP_SAMPLE:
                    begin
                        cap_reg[ix] <= raw_reg;
                        if (!raw_ok)
                        begin
                            inv_reg[ix] <= 1'b1;
                        end
                        else if (fac_zero)
                        begin
                            pot_reg[ix] <= cfg.absolute_max;
                            inv_reg[ix] <= 1'b0;
                        end
                    end
                    OP_MIN:    tw_reg[ix][0] <= 1'b1;
                    OP_MAX:    tw_reg[ix][1] <= 1'b1;
                    OP_FACTOR: ;
                endcase
            end
            if (ctl.writeback)
            begin
                if (op_reg == OP_SAMPLE)
                begin
                    pot_reg[ix] <= samp_val;
                    inv_reg[ix] <= 1'b0;
                end
                else
                begin
                    tw_reg[ix][2] <= 1'b1;
                end
            end
        end
    end

    // Report absent pots as zero.
    for (genvar g = 0; g < MAX_POTS; g++)
    begin : g_snap
        if (g < NUM_POTS)
        begin : g_on
            assign snap_pot[g] = pot_reg[g];
            assign snap_inv[g] = inv_reg[g];
        end
        else
        begin : g_off
            assign snap_pot[g] = '0;
            assign snap_inv[g] = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_out)
        begin
            for (int i = 0; i < MAX_POTS; i++)
                out_pot_reg[i] <= snap_pot[i];
            out_stat_reg <= {snap_inv, btn_reg};
        end
    end

    assign sts.need_div  = need_div;
    assign sts.last_chan = (op_reg == OP_SAMPLE) || idx_reg[0];
    assign sts.div_busy  = div_busy;
    assign sts.div_done  = div_done;

    assign joy1_x      = out_pot_reg[0];
    assign joy1_y      = out_pot_reg[1];
    assign joy2_x      = out_pot_reg[2];
    assign joy2_y      = out_pot_reg[3];
    assign status_byte = out_stat_reg;

endmodule

/* design/pts_ctrl.sv */
// ----------------------------------------------------------------------------
// pts_ctrl
// Sequencer for one item: execute, wait on the divider, hand off the word.
// ----------------------------------------------------------------------------
`include "pot_trim_scaler_macros.svh"

module pts_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output pts_pkg::pts_ctl_t ctl,
    input  pts_pkg::pts_sts_t sts
);
    import pts_pkg::*;

    pts_state_t state_reg;
    pts_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        ctl            = '0;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load_item = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                ctl.exec = 1'b1;
                if (sts.need_div)
                begin
                    ctl.div_start = 1'b1;
                    state_next    = ST_WAIT;
                end
                else if (sts.last_chan)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    ctl.next_chan = 1'b1;
                end
            end
            ST_WAIT:
            begin
                if (sts.div_done)
                begin
                    ctl.writeback = 1'b1;
                    if (sts.last_chan)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        ctl.next_chan = 1'b1;
                        state_next    = ST_EXEC;
                    end
                end
            end
            ST_DONE:
            begin
                // Hold until the output register is free or being drained.
                if (!out_valid_reg || !out_stall)
                begin
                    ctl.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    `PTS_ASSERT_HOLDS(a_no_overwrite, ctl.load_out, !(out_valid_reg && out_stall), "result word overwritten while stalled")
    `PTS_ASSERT_NEXT(a_accept_exec, in_valid && !in_stall, state_reg == ST_EXEC, "accepted word not executed")
    `PTS_ASSERT_HOLDS(a_wait_div, state_reg == ST_WAIT, sts.div_busy || sts.div_done, "waiting on an idle divider")
    `PTS_ASSERT_NEXT(a_div_runs, ctl.div_start, sts.div_busy, "divider did not start")

endmodule
